// ===== hdl/sdps_pkg.sv =====
// Package for the stereo delay pitch shifter: sizes, payload structs,
// sequencer states and multiplier operation codes.
// No dependencies.
`default_nettype none

package sdps_pkg;

  // Delay line geometry and sample format.
  localparam int unsigned LINE_DEPTH  = 2048;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned ADDR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned ENTRY_W     = 2 * SAMPLE_BITS;

  // Phase, fraction, fade and pitch formats.
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned FADE_W      = 17;
  localparam int unsigned PITCH_W     = 17;
  localparam int unsigned STEP_SHIFT  = 17;
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(32768);
  localparam logic [FADE_W-1:0]  FADE_ONE    = FADE_W'(65536);

  // Shared multiplier operand and product widths.
  localparam int unsigned OPA_W  = SAMPLE_BITS + 1;
  localparam int unsigned OPB_W  = FADE_W + 1;
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // Sequencer step counter.
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(4);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(8);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_READ  = 4'b0100,
    ST_MUL   = 4'b1000
  } state_e;

  // Multiplier operations, in issue order within one channel.
  typedef enum logic [1:0] {
    OP_DIFF1 = 2'd0,
    OP_DIFF2 = 2'd1,
    OP_MIX1  = 2'd2,
    OP_MIX2  = 2'd3
  } op_e;

endpackage

`default_nettype wire

// ===== hdl/sdps_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module sdps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stereo_delay_pitch_shifter_unit.sv =====
// Stereo delay-line pitch shifter with two crossfaded interpolating taps.
// Depends on sdps_pkg and sdps_ram.
//
// Usage: one stereo sample pair enters per input transaction (in_valid_i high
// and in_stall_o low at a clock edge) and produces one stereo output
// transaction (out_valid_o high and out_stall_i low). The pitch register is
// written over its own channel (cfg_valid_i and cfg_ready_o high); the user
// must write it only while the block is idle, which the block does not
// enforce. cfg_ready_o is always high. Each item runs through a small
// sequencer over one shared single-port delay memory that holds both
// channels: a write, four tap reads plus a step for the last read data,
// then eight operations on one shared 25x18 multiplier and a drain step.
// No new item is taken until the previous one is done; in_stall_o is high
// while an item is in flight.
// The output is held in a register, so a stalled receiver does not block
// the next input. If the previous result is still unread when the next one
// is done, the sequencer waits in its last step until the output frees up.
// Reset clears the write index, phase and fill tracking and loads the pitch
// default. The delay memory is not cleared: a fill flag and the write index
// mark entries never written, and those read as zero, so no clearing pass.
`default_nettype none

module stereo_delay_pitch_shifter_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sdps_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sdps_pkg::out_t                     out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sdps_pkg::PITCH_W-1:0]  cfg_data_i
);

  import sdps_pkg::*;

  localparam logic [ADDR_W-1:0]  HALF_LINE = ADDR_W'(LINE_DEPTH / 2);
  localparam logic [PROD_W-1:0]  RND_PROD  = PROD_W'(32768);
  localparam logic [SUM_W-1:0]   RND_SUM   = SUM_W'(32768);
  localparam int unsigned        RES_W     = SUM_W - FRAC_W;

  function automatic logic signed [SAMPLE_BITS-1:0] pick(
    input logic [ENTRY_W-1:0] entry,
    input logic               right
  );
    logic [SAMPLE_BITS-1:0] val;
    val = right ? entry[SAMPLE_BITS-1:0] : entry[ENTRY_W-1:SAMPLE_BITS];
    return signed'(val);
  endfunction

  // Control state.
  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [ADDR_W-1:0]      wpos_q, wpos_d;
  logic                   full_q, full_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [PITCH_W-1:0]     pitch_q;
  logic                   out_valid_q, out_valid_d;

  // Payload registers.
  in_t                    smp_q;
  logic [FADE_W-1:0]      fade_q;
  logic                   rd_valid_q;
  logic [ENTRY_W-1:0]     ent_q [4];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] acc_q;
  logic signed [SAMPLE_BITS-1:0] t1_q, t2_q, left_q;
  out_t                   out_q;

  // Memory port.
  logic                   ram_en, ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic                   accept, out_free, finish, rd_ok;
  logic [ADDR_W-1:0]      idx1, idx2;
  logic [FRAC_W-1:0]      frac;
  logic [PHASE_W:0]       phase_neg;
  logic [FADE_W-1:0]      fade_calc;
  logic [PITCH_W+STEP_SHIFT-1:0] step_wide;
  logic [PHASE_W-1:0]     step;

  op_e                    op, pop;
  logic                   ch, pch;
  logic [2:0]             pcnt;
  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SAMPLE_BITS-1:0] tap_val, tap_base;
  logic signed [SUM_W-1:0]  mix_sum;
  logic signed [RES_W-1:0]  mix_res;
  logic [RES_W-SAMPLE_BITS:0] mix_hi;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign finish      = (state_q == ST_MUL) && (cnt_q == MUL_LAST) && out_free;

  // Position = phase * LINE_DEPTH: integer part is the tap index, the next
  // 16 bits are the interpolation fraction.
  assign idx1 = phase_q[PHASE_W-1 -: ADDR_W];
  assign idx2 = idx1 ^ HALF_LINE;
  assign frac = phase_q[PHASE_W-1-ADDR_W -: FRAC_W];

  // Triangular fade, 0 at phase zero up to 65536 at half a turn.
  assign phase_neg = {1'b1, {PHASE_W{1'b0}}} - {1'b0, phase_q};
  assign fade_calc = phase_q[PHASE_W-1] ? phase_neg[PHASE_W-1 -: FADE_W]
                                        : phase_q[PHASE_W-1 -: FADE_W];

  assign step_wide = {pitch_q, {STEP_SHIFT{1'b0}}} >> ADDR_W;
  assign step      = step_wide[PHASE_W-1:0];

  // Entries never written read as zero: before the first wrap only indexes
  // one through the write index hold data.
  assign rd_ok = full_q || ((ram_addr != '0) && (ram_addr <= wpos_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wpos_d      = wpos_q;
    full_d      = full_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q & out_stall_i;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = wpos_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wpos_d  = wpos_q + ADDR_W'(1);
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
        if (wpos_q == '0) begin
          full_d = 1'b1;
        end
        cnt_d   = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        case (cnt_q[1:0])
          2'd0:    ram_addr = idx1;
          2'd1:    ram_addr = idx1 + ADDR_W'(1);
          2'd2:    ram_addr = idx2;
          default: ram_addr = idx2 + ADDR_W'(1);
        endcase
        if (cnt_q == READ_LAST) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          ram_en = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      ST_MUL: begin
        if (cnt_q != MUL_LAST) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          phase_d     = phase_q + step;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Issue side of the multiplier: left channel ops first, then right.
  assign op  = op_e'(cnt_q[1:0]);
  assign ch  = cnt_q[2];
  // Retire side handles the product issued in the previous cycle.
  assign pcnt = 3'(cnt_q - CNT_W'(1));
  assign pop  = op_e'(pcnt[1:0]);
  assign pch  = pcnt[2];

  always_comb begin
    opa = '0;
    opb = '0;
    case (op)
      OP_DIFF1: begin
        opa = OPA_W'(pick(ent_q[1], ch)) - OPA_W'(pick(ent_q[0], ch));
        opb = {2'b00, frac};
      end
      OP_DIFF2: begin
        opa = OPA_W'(pick(ent_q[3], ch)) - OPA_W'(pick(ent_q[2], ch));
        opb = {2'b00, frac};
      end
      OP_MIX1: begin
        opa = OPA_W'(t1_q);
        opb = {1'b0, fade_q};
      end
      OP_MIX2: begin
        opa = OPA_W'(t2_q);
        opb = {1'b0, FADE_ONE - fade_q};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_d = opa * opb;

  // Interpolated tap: base plus rounded fraction of the difference. The
  // true value lies between two samples, so the low bits are exact.
  assign rnd      = (prod_q + signed'(RND_PROD)) >>> FRAC_W;
  assign tap_base = (pop == OP_DIFF1) ? pick(ent_q[0], pch) : pick(ent_q[2], pch);
  assign tap_val  = tap_base + signed'(rnd[SAMPLE_BITS-1:0]);

  assign mix_sum = SUM_W'(acc_q) + SUM_W'(prod_q) + signed'(RND_SUM);
  assign mix_res = mix_sum[SUM_W-1:FRAC_W];
  assign mix_hi  = mix_res[RES_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&mix_hi) || ~(|mix_hi)) begin
      mix_sat = mix_res[SAMPLE_BITS-1:0];
    end else if (mix_res[RES_W-1]) begin
      mix_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      mix_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      wpos_q      <= '0;
      full_q      <= 1'b0;
      phase_q     <= '0;
      pitch_q     <= PITCH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wpos_q      <= wpos_d;
      full_q      <= full_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pitch_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_valid_q <= rd_ok;
    if (accept) begin
      smp_q <= in_data_i;
    end
    if (state_q == ST_WRITE) begin
      fade_q <= fade_calc;
    end
    if ((state_q == ST_READ) && (cnt_q != '0)) begin
      ent_q[2'(cnt_q[1:0] - 2'd1)] <= rd_valid_q ? ram_rdata : '0;
    end
    if (state_q == ST_MUL) begin
      if (cnt_q != MUL_LAST) begin
        prod_q <= prod_d;
      end
      if (cnt_q != '0) begin
        case (pop)
          OP_DIFF1: t1_q  <= tap_val;
          OP_DIFF2: t2_q  <= tap_val;
          OP_MIX1:  acc_q <= prod_q;
          OP_MIX2: begin
            if (!pch) begin
              left_q <= mix_sat;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (finish) begin
      out_q.left_out  <= left_q;
      out_q.right_out <= mix_sat;
    end
  end

  sdps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({smp_q.left_in, smp_q.right_in}),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // An accepted item always goes straight to its memory write.
  a_accept_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_WRITE))
    else $error("accepted item did not start with a write");

  // The write index moves by exactly one per accepted item.
  a_wpos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (wpos_q == ADDR_W'($past(wpos_q) + ADDR_W'(1))))
    else $error("write index did not advance by one");

  // Once every entry has been written, the line stays full until reset.
  a_full_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("fill flag dropped");

  // The read phase ends in the multiply phase, never back to idle.
  a_read_to_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_READ) && (cnt_q == READ_LAST)) |=> (state_q == ST_MUL))
    else $error("read sequence did not hand over to multiply");

  // The fade weight never exceeds unity while it is used.
  a_fade_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (fade_q <= FADE_ONE))
    else $error("fade weight above one");
`endif

endmodule

`default_nettype wire
